/* hw/rtl/i2a_pkg.sv */
// Shared types and constants for the integer to ASCII formatter.
package i2a_pkg;

    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned BCD_DIGITS = 20;
    localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
    localparam int unsigned HEX_DIGITS = VALUE_W / 4;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned LEFT_W     = 5;
    localparam int unsigned STEP_W     = 6;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W     = 1;
    localparam int unsigned QCNT_W     = 2;

    localparam logic [CHAR_W-1:0] CHR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHR_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CHR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHR_F     = 7'h46;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 7'h2D;

    typedef enum logic [1:0] {
        OP_UDEC = 2'd0,
        OP_SDEC = 2'd1,
        OP_HEX  = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    // One classified job passed from the front end to the back end.
    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic               hex;
    } t_job;

endpackage

/* hw/rtl/i2a_front.sv */
// Front end: accepts input transfers, works out the magnitude and the format.
module i2a_front (
    input  logic                         i_valid,
    input  logic [i2a_pkg::VALUE_W-1:0]  i_value,
    input  logic [1:0]                   i_opcode,
    input  logic                         i_full,
    output logic                         o_stall,
    output logic                         o_push,
    output i2a_pkg::t_job                o_job
);

    i2a_pkg::t_opcode op;
    logic             keep;

    assign op      = i2a_pkg::t_opcode'(i_opcode);
    assign o_stall = i_full;

    always_comb begin
        o_job.mag = i_value;
        o_job.neg = 1'b0;
        o_job.hex = 1'b0;
        keep      = 1'b1;
        unique case (op)
            i2a_pkg::OP_UDEC: begin
            end
            i2a_pkg::OP_SDEC: begin
                // The magnitude is taken in unsigned arithmetic, so the most
                // negative value comes out correctly.
                if (i_value[i2a_pkg::VALUE_W-1]) begin
                    o_job.neg = 1'b1;
                    o_job.mag = ~i_value + {{(i2a_pkg::VALUE_W-1){1'b0}}, 1'b1};
                end
            end
            i2a_pkg::OP_HEX: begin
                o_job.hex = 1'b1;
            end
            i2a_pkg::OP_NONE: begin
                keep = 1'b0;
            end
        endcase
    end

    // An unused opcode is accepted and produces no characters.
    assign o_push = i_valid && !i_full && keep;

endmodule

/* hw/rtl/i2a_queue.sv */
// Two-entry job queue between the front end and the back end.
module i2a_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  i2a_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output i2a_pkg::t_job  o_job
);

    i2a_pkg::t_job                  r_mem [i2a_pkg::QUEUE_DEPTH];
    logic [i2a_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [i2a_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [i2a_pkg::QCNT_W-1:0]     r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == i2a_pkg::QCNT_W'(i2a_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/i2a_back.sv */
// Back end: binary to BCD conversion and character emission.
module i2a_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  i2a_pkg::t_job                i_job,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [i2a_pkg::CHAR_W-1:0]   o_character,
    output logic                         o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_SKIP,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [i2a_pkg::VALUE_W-1:0]     r_bin;
    logic [i2a_pkg::BCD_W-1:0]       r_bcd;
    logic [i2a_pkg::STEP_W-1:0]      r_step;
    logic [i2a_pkg::LEFT_W-1:0]      r_left;
    logic                            r_neg;
    logic                            r_hex;
    logic                            r_out_valid;
    logic [i2a_pkg::CHAR_W-1:0]      r_character;
    logic                            r_last;

    logic [i2a_pkg::BCD_W-1:0]       bcd_adj;
    logic                            out_free;
    logic                            out_load;
    logic [3:0]                      nibble;
    logic [i2a_pkg::CHAR_W-1:0]      nib_char;

    // Each BCD digit of five or more gets three added before the shift.
    always_comb begin
        for (int d = 0; d < i2a_pkg::BCD_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    assign nibble = r_hex ? r_bin[i2a_pkg::VALUE_W-1 -: 4] : r_bcd[i2a_pkg::BCD_W-1 -: 4];

    always_comb begin
        if (nibble < 4'd10) begin
            nib_char = i2a_pkg::CHR_ZERO + {3'b000, nibble};
        end else begin
            nib_char = i2a_pkg::CHR_A + {3'b000, nibble} - 7'd10;
        end
    end

    assign out_free    = !r_out_valid || !i_stall;
    assign out_load    = out_free && ((r_state == S_SIGN) || (r_state == S_EMIT));
    assign o_pop       = (r_state == S_IDLE) && i_job_valid;
    assign o_valid     = r_out_valid;
    assign o_character = r_character;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_bin  <= i_job.mag;
                        r_neg  <= i_job.neg;
                        r_hex  <= i_job.hex;
                        r_bcd  <= '0;
                        r_step <= '0;
                        if (i_job.hex) begin
                            r_left  <= i2a_pkg::LEFT_W'(i2a_pkg::HEX_DIGITS);
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    r_bcd  <= {bcd_adj[i2a_pkg::BCD_W-2:0], r_bin[i2a_pkg::VALUE_W-1]};
                    r_bin  <= {r_bin[i2a_pkg::VALUE_W-2:0], 1'b0};
                    r_step <= r_step + 1'b1;
                    if (r_step == '1) begin
                        r_left  <= i2a_pkg::LEFT_W'(i2a_pkg::BCD_DIGITS);
                        r_state <= r_neg ? S_SIGN : S_SKIP;
                    end
                end
                S_SIGN: begin
                    if (out_free) begin
                        r_character <= i2a_pkg::CHR_MINUS;
                        r_last      <= 1'b0;
                        r_state     <= S_SKIP;
                    end
                end
                S_SKIP: begin
                    // Drop leading zero digits, but always keep the last one.
                    if (r_bcd[i2a_pkg::BCD_W-1 -: 4] == 4'd0 && r_left != 5'd1) begin
                        r_bcd  <= {r_bcd[i2a_pkg::BCD_W-5:0], 4'd0};
                        r_left <= r_left - 1'b1;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_character <= nib_char;
                        r_last      <= (r_left == 5'd1);
                        r_bcd       <= {r_bcd[i2a_pkg::BCD_W-5:0], 4'd0};
                        r_bin       <= {r_bin[i2a_pkg::VALUE_W-5:0], 4'd0};
                        r_left      <= r_left - 1'b1;
                        if (r_left == 5'd1) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/integer_to_ascii_formatter.sv */
// Top level of the integer to ASCII formatter.
// Each accepted value is printed as ASCII text, one character per output
// transfer, most significant first, with o_last on the final character.
// Opcode 0 gives unsigned decimal, 1 signed decimal with a leading minus sign
// when negative, 2 sixteen uppercase hex digits; opcode 3 is accepted and
// produces nothing. The front end takes a transfer whenever the two-entry job
// queue has room, so up to two values can wait while one is being printed.
// The back end handles one value at a time. A decimal value is loaded and
// converted by shift-and-add-three (one input bit a cycle); then a minus sign
// is printed when negative, leading zero digits (up to 19) are skipped, and
// the digits are printed one character per cycle while the output is not
// stalled. A hex value is loaded and its sixteen digits printed the same way.
module integer_to_ascii_formatter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [i2a_pkg::VALUE_W-1:0]  i_value,
    input  logic [1:0]                   i_opcode,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [i2a_pkg::CHAR_W-1:0]   o_character,
    output logic                         o_last
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    i2a_pkg::t_job front_job;
    i2a_pkg::t_job back_job;

    i2a_front u_front (
        .i_valid  (i_valid),
        .i_value  (i_value),
        .i_opcode (i_opcode),
        .i_full   (q_full),
        .o_stall  (o_stall),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    i2a_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (back_job)
    );

    i2a_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (back_job),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

/* hw/rtl/i2a_checker.sv */
// Port-level checks for the integer to ASCII formatter, bound to the top level.
module i2a_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_valid,
    input  logic                         i_stall,
    input  logic [i2a_pkg::CHAR_W-1:0]   o_character,
    input  logic                         o_last
);

    // A stalled output transfer keeps its character and flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_character) && $stable(o_last))
        else $error("stalled output transfer changed");

    // Every character is a digit, an uppercase hex letter or a minus sign.
    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_character >= i2a_pkg::CHR_ZERO && o_character <= i2a_pkg::CHR_NINE)
                  || (o_character >= i2a_pkg::CHR_A && o_character <= i2a_pkg::CHR_F)
                  || (o_character == i2a_pkg::CHR_MINUS)))
        else $error("character outside the output alphabet");

    // A minus sign is always followed by digits, so it never ends a string.
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_character == i2a_pkg::CHR_MINUS |-> !o_last)
        else $error("minus sign flagged as last character");

    // A minus sign that is taken is not directly followed by a second minus sign.
    a_minus_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_character == i2a_pkg::CHR_MINUS
        |=> !o_valid || o_character != i2a_pkg::CHR_MINUS)
        else $error("two minus signs in a row");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_character (o_character),
    .o_last      (o_last)
);
